[src/dutim_pkg.sv]
// ----------------------------------------------------------------------------
// dutim_pkg
// Types and codes shared by the up/down timer and its bus channels.
// ----------------------------------------------------------------------------
package dutim_pkg;

    localparam int BUS_W = 16;
    localparam int PSC_W = 16;

    typedef logic [1:0]       opcode_t;
    typedef logic [2:0]       reg_idx_t;
    typedef logic [BUS_W-1:0] bus_t;
    typedef logic [PSC_W-1:0] psc_t;

    localparam opcode_t OP_TICK  = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_WRITE = 2'd2;

    localparam reg_idx_t REG_CTRL   = 3'd0;
    localparam reg_idx_t REG_IER    = 3'd1;
    localparam reg_idx_t REG_STATUS = 3'd2;
    localparam reg_idx_t REG_EGR    = 3'd3;
    localparam reg_idx_t REG_CNT    = 3'd4;
    localparam reg_idx_t REG_PSC    = 3'd5;
    localparam reg_idx_t REG_ARR    = 3'd6;

    localparam int CTRL_EN_BIT  = 0;
    localparam int CTRL_OPM_BIT = 3;
    localparam int CTRL_DIR_BIT = 4;
    localparam int IER_UIE_BIT  = 0;
    localparam int SR_UIF_BIT   = 0;
    localparam int EGR_UG_BIT   = 0;

endpackage

[src/dutim_if.sv]
// ----------------------------------------------------------------------------
// dutim_req_if / dutim_rsp_if
// Valid/ready channels for timer requests and their responses.
// ----------------------------------------------------------------------------
interface dutim_req_if;
    import dutim_pkg::*;

    logic     valid;
    logic     ready;
    opcode_t  opcode;
    reg_idx_t reg_index;
    bus_t     write_data;

    modport source (output valid, output opcode, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input reg_index, input write_data,
                    output ready);
endinterface

interface dutim_rsp_if;
    import dutim_pkg::*;

    logic valid;
    logic ready;
    bus_t read_data;
    logic update_irq;

    modport source (output valid, output read_data, output update_irq, input ready);
    modport sink   (input valid, input read_data, input update_irq, output ready);
endinterface

[src/down_up_timer_with_one_pulse.sv]
// ----------------------------------------------------------------------------
// down_up_timer_with_one_pulse
// Up/down timer with prescaler, auto-reload and one-pulse mode.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transfer per bus cycle: a clock tick, a register read or a
//   register write (reg_index selects ctrl, irq enable, status, event gen,
//   counter, prescaler, reload). Every request yields exactly one rsp transfer
//   with read_data (zero unless a read) and update_irq (flag AND enable after
//   the request).
//   Each response is registered, in the skid entry while rsp stalls.
//   Throughput: one request per cycle while req.ready is high; timer state is
//   updated on each transfer, so back-to-back requests see each other's effects.
//   Stall: a result register plus one skid entry sit on rsp; req.ready drops
//   only while the skid entry is full, and no response is lost or repeated.
//   Reset: all control bits, counter and prescaler clear; reload is 16'hFFFF
//   cut or zero-extended to the counter width; the response buffer empties.
//   COUNTER_BITS sets the counter and reload width; the bus sees the low
//   16 bits, and writes clear the bits above them.
// ----------------------------------------------------------------------------
module down_up_timer_with_one_pulse #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dutim_req_if.sink   req,
    dutim_rsp_if.source rsp
);
    import dutim_pkg::*;

    localparam int CW = COUNTER_BITS;

    typedef logic [CW-1:0] cnt_t;

    localparam logic [CW+BUS_W-1:0] ARR_RST_EXT = {{CW{1'b0}}, {BUS_W{1'b1}}};
    localparam cnt_t                ARR_RST     = ARR_RST_EXT[CW-1:0];

    logic run_en_reg,  run_en_next;
    logic opm_reg,     opm_next;
    logic down_reg,    down_next;
    logic uie_reg,     uie_next;
    logic uif_reg,     uif_next;
    cnt_t cnt_reg,     cnt_next;
    cnt_t arr_reg,     arr_next;
    psc_t psc_pre_reg, psc_pre_next;
    psc_t psc_act_reg, psc_act_next;
    psc_t psc_cnt_reg, psc_cnt_next;

    bus_t rd_data;
    logic upd_evt;
    logic accept;

    logic [CW+BUS_W-1:0] wr_ext;
    logic [CW+BUS_W-1:0] cnt_ext;
    logic [CW+BUS_W-1:0] arr_ext;
    cnt_t                wr_cnt;

    logic out_valid_reg;
    bus_t out_rd_reg;
    logic out_irq_reg;
    logic skid_valid_reg;
    bus_t skid_rd_reg;
    logic skid_irq_reg;

    assign wr_ext  = {{CW{1'b0}}, req.write_data};
    assign wr_cnt  = wr_ext[CW-1:0];
    assign cnt_ext = {{BUS_W{1'b0}}, cnt_reg};
    assign arr_ext = {{BUS_W{1'b0}}, arr_reg};

    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        run_en_next  = run_en_reg;
        opm_next     = opm_reg;
        down_next    = down_reg;
        uie_next     = uie_reg;
        uif_next     = uif_reg;
        cnt_next     = cnt_reg;
        arr_next     = arr_reg;
        psc_pre_next = psc_pre_reg;
        psc_act_next = psc_act_reg;
        psc_cnt_next = psc_cnt_reg;
        rd_data      = '0;
        upd_evt      = 1'b0;

        unique case (req.opcode)
            OP_TICK:
            begin
                if (run_en_reg)
                begin
                    if (psc_cnt_reg != psc_act_reg)
                    begin
                        psc_cnt_next = psc_cnt_reg + psc_t'(1);
                    end
                    else
                    begin
                        psc_cnt_next = '0;
                        if (down_reg)
                        begin
                            if (cnt_reg == '0)
                            begin
                                upd_evt = 1'b1;
                                if (opm_reg)
                                begin
                                    run_en_next = 1'b0;
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_reg - cnt_t'(1);
                            end
                        end
                        else
                        begin
                            if (cnt_reg == arr_reg)
                            begin
                                upd_evt = 1'b1;
                                if (opm_reg)
                                begin
                                    run_en_next = 1'b0;
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_reg + cnt_t'(1);
                            end
                        end
                    end
                end
            end
            OP_READ:
            begin
                unique case (req.reg_index)
                    REG_CTRL:
                    begin
                        rd_data[CTRL_EN_BIT]  = run_en_reg;
                        rd_data[CTRL_OPM_BIT] = opm_reg;
                        rd_data[CTRL_DIR_BIT] = down_reg;
                    end
                    REG_IER:    rd_data[IER_UIE_BIT] = uie_reg;
                    REG_STATUS: rd_data[SR_UIF_BIT]  = uif_reg;
                    REG_CNT:    rd_data = cnt_ext[BUS_W-1:0];
                    REG_PSC:    rd_data = psc_pre_reg;
                    REG_ARR:    rd_data = arr_ext[BUS_W-1:0];
                    default:    rd_data = '0;
                endcase
            end
            OP_WRITE:
            begin
                unique case (req.reg_index)
                    REG_CTRL:
                    begin
                        run_en_next = req.write_data[CTRL_EN_BIT];
                        opm_next    = req.write_data[CTRL_OPM_BIT];
                        down_next   = req.write_data[CTRL_DIR_BIT];
                    end
                    REG_IER:    uie_next = req.write_data[IER_UIE_BIT];
                    REG_STATUS:
                    begin
                        if (!req.write_data[SR_UIF_BIT])
                        begin
                            uif_next = 1'b0;
                        end
                    end
                    REG_EGR:    upd_evt = req.write_data[EGR_UG_BIT];
                    REG_CNT:    cnt_next = wr_cnt;
                    REG_PSC:    psc_pre_next = req.write_data;
                    REG_ARR:    arr_next = wr_cnt;
                    default:    ;
                endcase
            end
            default: ;
        endcase

        if (upd_evt)
        begin
            cnt_next     = down_reg ? arr_reg : '0;
            psc_cnt_next = '0;
            psc_act_next = psc_pre_reg;
            uif_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_en_reg  <= 1'b0;
            opm_reg     <= 1'b0;
            down_reg    <= 1'b0;
            uie_reg     <= 1'b0;
            uif_reg     <= 1'b0;
            cnt_reg     <= '0;
            arr_reg     <= ARR_RST;
            psc_pre_reg <= '0;
            psc_act_reg <= '0;
            psc_cnt_reg <= '0;
        end
        else if (accept)
        begin
            run_en_reg  <= run_en_next;
            opm_reg     <= opm_next;
            down_reg    <= down_next;
            uie_reg     <= uie_next;
            uif_reg     <= uif_next;
            cnt_reg     <= cnt_next;
            arr_reg     <= arr_next;
            psc_pre_reg <= psc_pre_next;
            psc_act_reg <= psc_act_next;
            psc_cnt_reg <= psc_cnt_next;
        end
    end

    // result register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !rsp.ready)
        begin
            if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !rsp.ready)
        begin
            if (accept)
            begin
                skid_rd_reg  <= rd_data;
                skid_irq_reg <= uif_next && uie_next;
            end
        end
        else if (skid_valid_reg)
        begin
            out_rd_reg  <= skid_rd_reg;
            out_irq_reg <= skid_irq_reg;
        end
        else if (accept)
        begin
            out_rd_reg  <= rd_data;
            out_irq_reg <= uif_next && uie_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_rd_reg;
    assign rsp.update_irq = out_irq_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    a_psc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        psc_cnt_reg <= psc_act_reg)
        else $error("prescale count passed its division value");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.opcode == OP_TICK && !run_en_reg |=> $stable(cnt_reg))
        else $error("counter moved while disabled");

    a_overflow_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.opcode == OP_TICK && run_en_reg && !down_reg &&
        cnt_reg == arr_reg && psc_cnt_reg == psc_act_reg
        |=> uif_reg && cnt_reg == '0)
        else $error("overflow did not reload and flag");
`endif

endmodule
